// ----- hw/rtl/smf_pkg.sv -----
// ----------------------------------------------------------------------------
// smf_pkg: shared types and codes for the serial message framer
// Request payload structs, frame mode codes and configuration register
// indexes.
// ----------------------------------------------------------------------------
package smf_pkg;

  typedef struct packed {
    logic [7:0]  message_type;
    logic [31:0] payload_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       type_error;
  } out_item_t;

  // Handshake between the frame engine and the top level
  typedef struct packed {
    logic emit;     // result is valid this cycle
    logic consume;  // held input request is used up
  } eng_ctl_t;

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_PAYLOAD = 2'd1;
  localparam logic [1:0] MODE_DROP    = 2'd2;

  localparam logic [1:0] REG_START_BYTE = 2'd0;
  localparam logic [1:0] REG_NODE_BYTE  = 2'd1;
  localparam logic [1:0] REG_TYPE_LIMIT = 2'd2;

  localparam logic [8:0] TYPE_LIMIT_RESET = 9'd256;

endpackage

// ----- hw/rtl/smf_engine.sv -----
// ----------------------------------------------------------------------------
// smf_engine: frame sequencer
// Turns the held input request into frame bytes, one per cycle while the
// output is open, tracking mode, payload count and running checksum.
// ----------------------------------------------------------------------------
module smf_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  smf_pkg::in_item_t  item,
  input  logic               out_open,
  input  logic [7:0]         start_byte,
  input  logic [7:0]         node_byte,
  input  logic [8:0]         type_limit,
  output smf_pkg::eng_ctl_t  ctl,
  output smf_pkg::out_item_t res
);

  // byte positions within a frame's first request
  localparam logic [3:0] STEP_START = 4'd0;
  localparam logic [3:0] STEP_NODE  = 4'd1;
  localparam logic [3:0] STEP_TYPE  = 4'd2;
  localparam logic [3:0] STEP_LEN3  = 4'd3;
  localparam logic [3:0] STEP_LEN2  = 4'd4;
  localparam logic [3:0] STEP_LEN1  = 4'd5;
  localparam logic [3:0] STEP_LEN0  = 4'd6;
  localparam logic [3:0] STEP_DATA  = 4'd7;
  localparam logic [3:0] STEP_SUM   = 4'd8;

  logic [1:0]  mode, mode_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [3:0]  step, step_next;

  logic        type_bad;
  logic        len_zero;
  logic [7:0]  hdr_byte;

  assign type_bad = ({1'b0, item.message_type} >= type_limit);
  assign len_zero = (item.payload_length == 32'd0);

  always_comb begin
    unique case (step)
      STEP_START: hdr_byte = start_byte;
      STEP_NODE:  hdr_byte = node_byte;
      STEP_TYPE:  hdr_byte = item.message_type;
      STEP_LEN3:  hdr_byte = item.payload_length[31:24];
      STEP_LEN2:  hdr_byte = item.payload_length[23:16];
      STEP_LEN1:  hdr_byte = item.payload_length[15:8];
      STEP_LEN0:  hdr_byte = item.payload_length[7:0];
      default:    hdr_byte = item.data_byte;
    endcase
  end

  always_comb begin
    ctl              = '0;
    res              = '0;
    mode_next        = mode;
    bytes_left_next  = bytes_left;
    running_sum_next = running_sum;
    step_next        = step;

    if (item_valid) begin
      unique case (mode)
        smf_pkg::MODE_PAYLOAD: begin
          if (out_open) begin
            ctl.emit = 1'b1;
            if (step == STEP_START) begin
              res.out_byte     = item.data_byte;
              running_sum_next = running_sum + item.data_byte;
              bytes_left_next  = bytes_left - 32'd1;
              if (bytes_left == 32'd1) begin
                step_next = STEP_NODE;  // checksum follows on the same request
              end else begin
                ctl.consume = 1'b1;
              end
            end else begin
              res.out_byte     = running_sum;
              res.frame_end    = 1'b1;
              running_sum_next = '0;
              mode_next        = smf_pkg::MODE_IDLE;
              step_next        = STEP_START;
              ctl.consume      = 1'b1;
            end
          end
        end
        smf_pkg::MODE_DROP: begin
          // dropped payload needs no output slot
          ctl.consume     = 1'b1;
          bytes_left_next = bytes_left - 32'd1;
          if (bytes_left == 32'd1) begin
            mode_next = smf_pkg::MODE_IDLE;
          end
        end
        default: begin
          if (out_open) begin
            ctl.emit = 1'b1;
            if (step == STEP_START && type_bad) begin
              res.frame_end    = 1'b1;
              res.type_error   = 1'b1;
              running_sum_next = '0;
              ctl.consume      = 1'b1;
              if (item.payload_length > 32'd1) begin
                bytes_left_next = item.payload_length - 32'd1;
                mode_next       = smf_pkg::MODE_DROP;
              end else begin
                bytes_left_next = '0;
                mode_next       = smf_pkg::MODE_IDLE;
              end
            end else if (step == STEP_SUM || (step == STEP_DATA && len_zero)) begin
              res.out_byte     = running_sum;
              res.frame_end    = 1'b1;
              running_sum_next = '0;
              bytes_left_next  = '0;
              mode_next        = smf_pkg::MODE_IDLE;
              step_next        = STEP_START;
              ctl.consume      = 1'b1;
            end else begin
              res.out_byte = hdr_byte;
              if (step == STEP_START) begin
                running_sum_next = hdr_byte;
              end else begin
                running_sum_next = running_sum + hdr_byte;
              end
              if (step == STEP_DATA) begin
                bytes_left_next = item.payload_length - 32'd1;
                if (item.payload_length == 32'd1) begin
                  step_next = STEP_SUM;
                end else begin
                  mode_next   = smf_pkg::MODE_PAYLOAD;
                  step_next   = STEP_START;
                  ctl.consume = 1'b1;
                end
              end else begin
                step_next = step + 4'd1;
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= smf_pkg::MODE_IDLE;
      bytes_left  <= '0;
      running_sum <= '0;
      step        <= STEP_START;
    end else begin
      mode        <= mode_next;
      bytes_left  <= bytes_left_next;
      running_sum <= running_sum_next;
      step        <= step_next;
    end
  end

endmodule

// ----- hw/rtl/serial_message_framer.sv -----
// ----------------------------------------------------------------------------
// serial_message_framer: byte framer with additive checksum
// Wraps payload bytes in start, node, type and length header bytes and
// closes each frame with a modulo-256 checksum byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_item): the first request of a frame
//   carries type and length plus the first payload byte; later requests
//   carry one payload byte each. A zero-length frame is one request.
//   Output channel (out_valid/out_stall/out_item): one result per frame
//   byte, frame_end on the checksum byte. A type at or above type_limit
//   gives one error result and the frame's payload requests are swallowed.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//   write only while the framer is idle.
// Timing:
//   A request is registered on accept in the input register; its results
//   are registered in the output register. Payload requests run at one per
//   cycle unless the output stalls; the last one of a frame also gives the
//   checksum byte. A frame's first request holds the sequencer for the
//   header plus checksum or first payload byte (plus checksum for a one-byte
//   frame), a rejected type for its error result; in_stall stays high until
//   its last byte. Dropped payload runs at one request per cycle, no output.
// Reset: rst (synchronous) empties both registers, returns to idle and
//   restores start 0, node 0, type_limit 256.
// Stall: out_stall holds the output register; the sequencer halts, but for
//   dropped payload, and once the input register is full, in_stall rises.
// ----------------------------------------------------------------------------
module serial_message_framer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  smf_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output smf_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data
);

  logic [7:0]         start_byte;
  logic [7:0]         node_byte;
  logic [8:0]         type_limit;

  logic               item_valid;
  smf_pkg::in_item_t  item;

  logic               out_open;
  smf_pkg::eng_ctl_t  ctl;
  smf_pkg::out_item_t res;

  // config registers: always ready, unknown indexes ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= '0;
      node_byte  <= '0;
      type_limit <= smf_pkg::TYPE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        smf_pkg::REG_START_BYTE: start_byte <= cfg_data[7:0];
        smf_pkg::REG_NODE_BYTE:  node_byte  <= cfg_data[7:0];
        smf_pkg::REG_TYPE_LIMIT: type_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register: hold the request until the sequencer consumes it;
  // a new request can load in the same cycle the old one is consumed
  assign in_stall = item_valid && !ctl.consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (ctl.consume) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_item;
    end
  end

  // output register opens when empty or being drained this cycle
  assign out_open = !out_valid || !out_stall;

  smf_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .out_open   (out_open),
    .start_byte (start_byte),
    .node_byte  (node_byte),
    .type_limit (type_limit),
    .ctl        (ctl),
    .res        (res)
  );

  // result register: advance when open, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_open) begin
      out_valid <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_open && ctl.emit) begin
      out_item <= res;
    end
  end

endmodule

// ----- sim/smf_checker.sv -----
// ----------------------------------------------------------------------------
// smf_checker: frame byte predictor and result scoreboard
// Watches the request, result and register channels of the framer, rebuilds
// each frame's bytes from accepted requests and compares them in order.
// ----------------------------------------------------------------------------
module smf_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  smf_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  smf_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  output int                 pending,
  output int                 fail_count
);

  logic [7:0]         start_val;
  logic [7:0]         node_val;
  logic [8:0]         limit_val;
  logic [1:0]         mode_q;
  logic [31:0]        left_q;
  logic [7:0]         sum_q;
  smf_pkg::out_item_t frame_bytes_q[$];
  int                 errors = 0;

  assign fail_count = errors;

  task automatic report_mismatch(input string msg);
    $display("%0t smf_checker: %s", $time, msg);
    errors++;
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic fin, input logic err);
    smf_pkg::out_item_t r;
    r.out_byte   = b;
    r.frame_end  = fin;
    r.type_error = err;
    frame_bytes_q.push_back(r);
  endtask

  task automatic send_byte(input logic [7:0] b);
    sum_q = sum_q + b;
    queue_byte(b, 1'b0, 1'b0);
  endtask

  task automatic close_frame();
    queue_byte(sum_q, 1'b1, 1'b0);
    sum_q  = '0;
    mode_q = smf_pkg::MODE_IDLE;
  endtask

  task automatic predict_frame_bytes(input smf_pkg::in_item_t req);
    case (mode_q)
      smf_pkg::MODE_PAYLOAD: begin
        send_byte(req.data_byte);
        left_q = left_q - 1;
        if (left_q == 0) close_frame();
      end
      smf_pkg::MODE_DROP: begin
        left_q = left_q - 1;
        if (left_q == 0) mode_q = smf_pkg::MODE_IDLE;
      end
      default: begin
        if ({1'b0, req.message_type} >= limit_val) begin
          queue_byte(8'h00, 1'b1, 1'b1);
          sum_q = '0;
          if (req.payload_length > 1) begin
            left_q = req.payload_length - 1;
            mode_q = smf_pkg::MODE_DROP;
          end else begin
            left_q = '0;
            mode_q = smf_pkg::MODE_IDLE;
          end
        end else begin
          sum_q = '0;
          send_byte(start_val);
          send_byte(node_val);
          send_byte(req.message_type);
          send_byte(req.payload_length[31:24]);
          send_byte(req.payload_length[23:16]);
          send_byte(req.payload_length[15:8]);
          send_byte(req.payload_length[7:0]);
          if (req.payload_length == 0) begin
            left_q = '0;
            close_frame();
          end else begin
            send_byte(req.data_byte);
            left_q = req.payload_length - 1;
            if (left_q == 0) close_frame();
            else mode_q = smf_pkg::MODE_PAYLOAD;
          end
        end
      end
    endcase
  endtask

  task automatic check_result(input smf_pkg::out_item_t got);
    smf_pkg::out_item_t want;
    if (frame_bytes_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: byte %h end %b err %b",
                                got.out_byte, got.frame_end, got.type_error));
      return;
    end
    want = frame_bytes_q.pop_front();
    if (got.out_byte !== want.out_byte)
      report_mismatch($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
    if (got.frame_end !== want.frame_end)
      report_mismatch($sformatf("frame_end %b, expected %b", got.frame_end, want.frame_end));
    if (got.type_error !== want.type_error)
      report_mismatch($sformatf("type_error %b, expected %b", got.type_error,
                                want.type_error));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start_val = '0;
      node_val  = '0;
      limit_val = smf_pkg::TYPE_LIMIT_RESET;
      mode_q    = smf_pkg::MODE_IDLE;
      left_q    = '0;
      sum_q     = '0;
      frame_bytes_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          smf_pkg::REG_START_BYTE: start_val = cfg_data[7:0];
          smf_pkg::REG_NODE_BYTE:  node_val  = cfg_data[7:0];
          smf_pkg::REG_TYPE_LIMIT: limit_val = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_frame_bytes(in_item);
      if (out_valid && !out_stall) check_result(out_item);
    end
    pending <= frame_bytes_q.size();
  end

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for the serial message framer
// Drives frame requests in random bursts, stalls the result side on its own
// pattern and rewrites the header and type limit registers between phases.
// A side checker predicts every frame byte and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ITEM_TARGET   = 310;   // stop making frames past this
  localparam int SETTLE_CYCLES = 16;    // quiet time after the last result
  localparam int IDLE_LIMIT    = 4000;  // cycles with no handshake at all

  // Register index with no register behind it; writes must be ignored
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  smf_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  smf_pkg::out_item_t out_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = smf_pkg::REG_START_BYTE;
  logic [8:0]         cfg_data = '0;

  int pending;
  int fail_count;
  int items_sent  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  stall_style_t stall_style = STALL_NONE;
  int           stall_span  = 0;

  serial_message_framer i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  smf_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: pick a stall style for a random stretch of cycles. One style
  // never stalls, so the framer also gets long runs at full rate.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      stall_span  = $urandom_range(20, 150);
    end else begin
      stall_span--;
    end
    case (stall_style)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 30);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 99) < 75);
      STALL_PERIODIC: out_stall <= ((stall_span % 7) < 3);
      default:        out_stall <= 1'b0;
    endcase
  end

  // Watchdog: give up once no channel has moved for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("** serial_message_framer: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one request and hold it until accepted. Between bursts, drop
  // valid for a random gap so idle cycles land on every header phase.
  task automatic push_req(input smf_pkg::in_item_t req);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_item  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Send one whole frame. With fixed set, every payload byte is fill;
  // fields that the framer ignores on later requests carry junk.
  task automatic send_frame(input logic [7:0] mtype, input logic [31:0] len,
                            input logic fixed, input logic [7:0] fill);
    smf_pkg::in_item_t req;
    int unsigned       rest;
    req.message_type   = mtype;
    req.payload_length = len;
    req.data_byte      = fixed ? fill : 8'($urandom);
    push_req(req);
    rest = (len == 0) ? 0 : len - 1;
    repeat (rest) begin
      req.message_type   = 8'($urandom);
      req.payload_length = $urandom;
      req.data_byte      = fixed ? fill : 8'($urandom);
      push_req(req);
    end
  endtask

  // Write one register, then drop valid before the next write
  task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop requests, wait for every predicted byte, then let a dropped
  // payload tail finish inside the framer before touching registers.
  task automatic drain_framer();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [8:0]  lim;
    logic [31:0] len;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: zero-length frame (data byte ignored), one-byte frame
    // and a short frame whose sum wraps past 0xff.
    send_frame(8'h00, 32'd0, 1'b1, 8'hFF);
    send_frame(8'hFF, 32'd1, 1'b1, 8'hFF);
    send_frame(8'h5A, 32'd3, 1'b1, 8'h80);
    drain_framer();

    // Extreme header bytes; bit 8 of the node write must be masked off
    write_reg(smf_pkg::REG_START_BYTE, 9'h0FF);
    write_reg(smf_pkg::REG_NODE_BYTE, 9'h1AA);
    write_reg(smf_pkg::REG_TYPE_LIMIT, 9'h010);
    send_frame(8'h10, 32'd0, 1'b1, 8'h00);   // type equal to limit: reject
    send_frame(8'h0F, 32'd1, 1'b1, 8'h00);   // just below limit: accept
    send_frame(8'hFF, 32'd1, 1'b1, 8'h55);   // reject, no payload to drop
    send_frame(8'h80, 32'd4, 1'b0, 8'h00);   // reject, drop three requests
    drain_framer();

    write_reg(smf_pkg::REG_TYPE_LIMIT, 9'd0);    // every type rejected
    send_frame(8'h00, 32'd2, 1'b0, 8'h00);
    drain_framer();
    write_reg(smf_pkg::REG_TYPE_LIMIT, 9'd511);  // above 256: every type passes
    send_frame(8'hFF, 32'd2, 1'b1, 8'h00);
    drain_framer();
    write_reg(smf_pkg::REG_TYPE_LIMIT, 9'd1);
    send_frame(8'h00, 32'd0, 1'b0, 8'h00);
    send_frame(8'h01, 32'd0, 1'b0, 8'h00);
    drain_framer();
    write_reg(REG_UNUSED, 9'($urandom));

    // Random phases: new settings, then a handful of well-formed frames.
    // Most limits sit high so most frames go through with random content.
    while (items_sent < ITEM_TARGET) begin
      drain_framer();
      case ($urandom_range(0, 7))
        0:       lim = 9'd0;
        1:       lim = 9'd256;
        2:       lim = 9'd511;
        3:       lim = 9'($urandom_range(0, 511));
        4:       lim = 9'd1;
        default: lim = 9'($urandom_range(128, 256));
      endcase
      write_reg(smf_pkg::REG_START_BYTE, 9'($urandom_range(0, 511)));
      write_reg(smf_pkg::REG_NODE_BYTE, 9'($urandom_range(0, 511)));
      write_reg(smf_pkg::REG_TYPE_LIMIT, lim);
      repeat ($urandom_range(3, 10)) begin
        case ($urandom_range(0, 19))
          0:             len = $urandom_range(17, 48);
          1, 2, 3, 4, 5: len = $urandom_range(5, 16);
          default:       len = $urandom_range(0, 4);
        endcase
        send_frame(8'($urandom_range(0, 255)), len, 1'b0, 8'h00);
      end
    end

    drain_framer();
    if (fail_count == 0) begin
      $display("** serial_message_framer: PASSED **");
    end else begin
      $display("** serial_message_framer: FAILED **");
    end
    $finish;
  end

endmodule
